>>> src/assert_macros.svh
// Assertion macros for the line stepper.
// Clocked on clk, disabled while rst_n is low; used by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication property on every clock edge out of reset.
`define BLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a clock edge out of reset.
`define BLS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> src/bls_pkg.sv
// Package for the line stepper: image size, command codes and beat types.
// No dependencies; used by every module of the block.
package bls_pkg;

    localparam int IMAGE_WIDTH  = 1600;
    localparam int IMAGE_HEIGHT = 1600;

    localparam int COORD_W  = 12;
    localparam int ERR_W    = 13;
    localparam int OFFSET_W = 23;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef struct packed {
        logic                       mode;
        logic signed [COORD_W-1:0]  x_start;
        logic signed [COORD_W-1:0]  y_start;
        logic signed [COORD_W-1:0]  x_end;
        logic signed [COORD_W-1:0]  y_end;
        logic [7:0]                 red;
        logic [7:0]                 green;
        logic [7:0]                 blue;
    } cmd_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  pixel_x;
        logic signed [COORD_W-1:0]  pixel_y;
        logic                       inside_res;
        logic [OFFSET_W-1:0]        byte_offset;
        logic [7:0]                 out_red;
        logic [7:0]                 out_green;
        logic [7:0]                 out_blue;
        logic                       last;
    } pix_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  major_pos;
        logic signed [COORD_W-1:0]  major_stop;
        logic signed [COORD_W-1:0]  minor_pos;
        logic signed [ERR_W-1:0]    err_term;
        logic [COORD_W-1:0]         delta_major;
        logic [COORD_W-1:0]         delta_minor;
        logic                       steep_flag;
        logic                       minor_down;
        logic [23:0]                line_color;
    } line_state_t;

endpackage

>>> src/bls_setup.sv
// Line setup: steepness test, endpoint ordering, deltas and initial error.
// Depends on bls_pkg for the command and line state types.
module bls_setup
(
    input  bls_pkg::cmd_item_t   cmd,
    output bls_pkg::line_state_t line
);

    logic signed [bls_pkg::COORD_W:0]   dx;
    logic signed [bls_pkg::COORD_W:0]   dy;
    logic [bls_pkg::COORD_W:0]          adx;
    logic [bls_pkg::COORD_W:0]          ady;
    logic                               steep;
    logic signed [bls_pkg::COORD_W-1:0] a0;
    logic signed [bls_pkg::COORD_W-1:0] a1;
    logic signed [bls_pkg::COORD_W-1:0] b0;
    logic signed [bls_pkg::COORD_W-1:0] b1;
    logic                               swap;
    logic signed [bls_pkg::COORD_W-1:0] lo_a;
    logic signed [bls_pkg::COORD_W-1:0] hi_a;
    logic signed [bls_pkg::COORD_W-1:0] lo_b;
    logic signed [bls_pkg::COORD_W-1:0] hi_b;
    logic signed [bls_pkg::COORD_W:0]   dmaj;
    logic signed [bls_pkg::COORD_W:0]   dmin;
    logic [bls_pkg::COORD_W:0]          admin;

    assign dx  = (bls_pkg::COORD_W+1)'(cmd.x_end) - (bls_pkg::COORD_W+1)'(cmd.x_start);
    assign dy  = (bls_pkg::COORD_W+1)'(cmd.y_end) - (bls_pkg::COORD_W+1)'(cmd.y_start);
    assign adx = dx[bls_pkg::COORD_W] ? -dx : dx;
    assign ady = dy[bls_pkg::COORD_W] ? -dy : dy;
    assign steep = ady > adx;

    assign a0 = steep ? cmd.y_start : cmd.x_start;
    assign b0 = steep ? cmd.x_start : cmd.y_start;
    assign a1 = steep ? cmd.y_end   : cmd.x_end;
    assign b1 = steep ? cmd.x_end   : cmd.y_end;

    assign swap = a0 > a1;
    assign lo_a = swap ? a1 : a0;
    assign hi_a = swap ? a0 : a1;
    assign lo_b = swap ? b1 : b0;
    assign hi_b = swap ? b0 : b1;

    assign dmaj  = (bls_pkg::COORD_W+1)'(hi_a) - (bls_pkg::COORD_W+1)'(lo_a);
    assign dmin  = (bls_pkg::COORD_W+1)'(hi_b) - (bls_pkg::COORD_W+1)'(lo_b);
    assign admin = dmin[bls_pkg::COORD_W] ? -dmin : dmin;

    always_comb
    begin
        line.major_pos   = lo_a;
        line.major_stop  = hi_a;
        line.minor_pos   = lo_b;
        line.delta_major = dmaj[bls_pkg::COORD_W-1:0];
        line.delta_minor = admin[bls_pkg::COORD_W-1:0];
        line.err_term    = bls_pkg::ERR_W'(dmaj[bls_pkg::COORD_W-1:1]);
        line.steep_flag  = steep;
        line.minor_down  = !(lo_b < hi_b);
        line.line_color  = {cmd.red, cmd.green, cmd.blue};
    end

endmodule

>>> src/bls_pixel.sv
// Pixel formatting: x/y unswap, image bounds test, RGB byte offset, last mark.
// Depends on bls_pkg for the line state and pixel beat types.
module bls_pixel
(
    input  bls_pkg::line_state_t line,
    output bls_pkg::pix_item_t   pix
);

    logic signed [bls_pkg::COORD_W-1:0] px;
    logic signed [bls_pkg::COORD_W-1:0] py;
    logic                               in_image;
    logic [21:0]                        row_base;
    logic [22:0]                        lin;
    logic [24:0]                        off3;

    assign px = line.steep_flag ? line.minor_pos : line.major_pos;
    assign py = line.steep_flag ? line.major_pos : line.minor_pos;

    assign in_image = !px[bls_pkg::COORD_W-1] && !py[bls_pkg::COORD_W-1]
                   && ({1'b0, px[10:0]} < 12'(bls_pkg::IMAGE_WIDTH))
                   && ({1'b0, py[10:0]} < 12'(bls_pkg::IMAGE_HEIGHT));

    // y*width+x, then times three as x + 2x
    assign row_base = 22'(py[10:0]) * 22'(bls_pkg::IMAGE_WIDTH);
    assign lin      = {1'b0, row_base} + 23'(px[10:0]);
    assign off3     = {2'b00, lin} + {1'b0, lin, 1'b0};

    always_comb
    begin
        pix.pixel_x     = px;
        pix.pixel_y     = py;
        pix.inside_res  = in_image;
        pix.byte_offset = in_image ? off3[bls_pkg::OFFSET_W-1:0] : '0;
        pix.out_red     = line.line_color[23:16];
        pix.out_green   = line.line_color[15:8];
        pix.out_blue    = line.line_color[7:0];
        pix.last        = (line.major_pos == line.major_stop);
    end

endmodule

>>> src/bls_out_buf.sv
// Two-entry output buffer (main register plus skid) for pixel beats.
// Depends on bls_pkg for the pixel beat type.
module bls_out_buf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bls_pkg::pix_item_t push_data,
    output logic               space,
    output logic               pix_valid,
    input  logic               pix_ready,
    output bls_pkg::pix_item_t pix
);

    logic               main_valid_reg;
    logic               main_valid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;
    bls_pkg::pix_item_t main_reg;
    bls_pkg::pix_item_t main_next;
    bls_pkg::pix_item_t skid_reg;
    bls_pkg::pix_item_t skid_next;
    logic               pop;

    assign space     = !skid_valid_reg;
    assign pix_valid = main_valid_reg;
    assign pix       = main_reg;
    assign pop       = main_valid_reg && pix_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_next = push_data;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

>>> src/bresenham_line_stepper.sv
// Bresenham line stepper, top level: line state registers and error update.
// A step beat accepted on an active line pushes its pixel beat into the buffer.
// Throughput: one command beat per cycle while the two-entry output buffer has room.
// Reset (rst_n low, asynchronous) clears the line state, goes idle, empties the buffer.
// Depends on bls_pkg, bls_setup, bls_pixel, bls_out_buf and assert_macros.svh.
`include "assert_macros.svh"

module bresenham_line_stepper
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  bls_pkg::cmd_item_t cmd,
    output logic               pix_valid,
    input  logic               pix_ready,
    output bls_pkg::pix_item_t pix
);

    bls_pkg::line_state_t line_reg;
    bls_pkg::line_state_t line_next;
    bls_pkg::line_state_t load_line;
    bls_pkg::pix_item_t   cur_pix;
    logic                 active_reg;
    logic                 active_next;
    logic                 accept;
    logic                 is_step;
    logic                 emit;
    logic                 fin;
    logic signed [bls_pkg::ERR_W:0] err_dec;
    logic signed [bls_pkg::ERR_W:0] err_fix;

    bls_setup u_setup
    (
        .cmd  (cmd),
        .line (load_line)
    );

    bls_pixel u_pixel
    (
        .line (line_reg),
        .pix  (cur_pix)
    );

    bls_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (cur_pix),
        .space     (cmd_ready),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    assign accept  = cmd_valid && cmd_ready;
    assign is_step = (cmd.mode == bls_pkg::MODE_STEP);
    assign emit    = accept && is_step && active_reg;
    assign fin     = cur_pix.last;

    assign err_dec = (bls_pkg::ERR_W+1)'(line_reg.err_term)
                   - (bls_pkg::ERR_W+1)'(line_reg.delta_minor);
    assign err_fix = err_dec + (bls_pkg::ERR_W+1)'(line_reg.delta_major);

    always_comb
    begin
        line_next   = line_reg;
        active_next = active_reg;
        if (accept && !is_step)
        begin
            line_next   = load_line;
            active_next = 1'b1;
        end
        else if (emit)
        begin
            if (fin)
            begin
                active_next = 1'b0;
            end
            else
            begin
                // advance major axis, step minor axis when error goes negative
                line_next.major_pos = line_reg.major_pos + 12'sd1;
                if (err_dec[bls_pkg::ERR_W])
                begin
                    line_next.err_term  = err_fix[bls_pkg::ERR_W-1:0];
                    line_next.minor_pos = line_reg.minor_down
                                        ? line_reg.minor_pos - 12'sd1
                                        : line_reg.minor_pos + 12'sd1;
                end
                else
                begin
                    line_next.err_term = err_dec[bls_pkg::ERR_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg   <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            line_reg   <= line_next;
            active_reg <= active_next;
        end
    end

    `BLS_ASSERT(a_load_activates, (accept && !is_step) |=> active_reg, "load did not activate")
    `BLS_ASSERT(a_last_idles, (emit && fin) |=> !active_reg, "last pixel did not go idle")
    `BLS_ASSERT(a_major_advance, (emit && !fin) |=> (line_reg.major_pos == $past(line_reg.major_pos) + 12'sd1), "major axis did not advance")
    `BLS_ASSERT_NEVER(a_err_nonneg, active_reg && line_reg.err_term[bls_pkg::ERR_W-1], "error term negative while active")

endmodule

>>> bench/bresenham_line_stepper_chk.sv
`timescale 1ns / 100ps
// Pixel checker for the line stepper: follows accepted command beats, predicts each
// pixel beat and compares the pixel channel against it. Depends on bls_pkg.
module bresenham_line_stepper_chk
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_ready,
    input  bls_pkg::cmd_item_t cmd,
    input  logic               pix_valid,
    input  logic               pix_ready,
    input  bls_pkg::pix_item_t pix,
    output int                 errors,
    output int                 pending
);

    bls_pkg::line_state_t line_st;
    logic                 drawing;
    bls_pkg::pix_item_t   pixel_q[$];

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic string show(input bls_pkg::pix_item_t p);
        return $sformatf("x=%0d y=%0d in=%0b off=%0d rgb=%h%h%h last=%0b",
                         p.pixel_x, p.pixel_y, p.inside_res, p.byte_offset,
                         p.out_red, p.out_green, p.out_blue, p.last);
    endfunction

    function automatic void start_line(input bls_pkg::cmd_item_t c);
        int   a0, b0, a1, b1, t;
        logic steep;
        a0 = c.x_start;
        b0 = c.y_start;
        a1 = c.x_end;
        b1 = c.y_end;
        steep = mag(b1 - b0) > mag(a1 - a0);
        if (steep)
        begin
            t = a0; a0 = b0; b0 = t;
            t = a1; a1 = b1; b1 = t;
        end
        if (a0 > a1)
        begin
            t = a0; a0 = a1; a1 = t;
            t = b0; b0 = b1; b1 = t;
        end
        line_st.major_pos   = bls_pkg::COORD_W'(a0);
        line_st.major_stop  = bls_pkg::COORD_W'(a1);
        line_st.minor_pos   = bls_pkg::COORD_W'(b0);
        line_st.delta_major = bls_pkg::COORD_W'(a1 - a0);
        line_st.delta_minor = bls_pkg::COORD_W'(mag(b1 - b0));
        line_st.err_term    = bls_pkg::ERR_W'((a1 - a0) / 2);
        line_st.minor_down  = !(b0 < b1);
        line_st.steep_flag  = steep;
        line_st.line_color  = {c.red, c.green, c.blue};
        drawing = 1'b1;
    endfunction

    function automatic void next_pixel();
        bls_pkg::pix_item_t p;
        int                 px, py, err, dmaj, dmin;
        if (!drawing)
            return;
        px = line_st.steep_flag ? line_st.minor_pos : line_st.major_pos;
        py = line_st.steep_flag ? line_st.major_pos : line_st.minor_pos;
        p.pixel_x     = bls_pkg::COORD_W'(px);
        p.pixel_y     = bls_pkg::COORD_W'(py);
        p.inside_res  = px >= 0 && px < bls_pkg::IMAGE_WIDTH
                     && py >= 0 && py < bls_pkg::IMAGE_HEIGHT;
        p.byte_offset = p.inside_res
                      ? bls_pkg::OFFSET_W'((py * bls_pkg::IMAGE_WIDTH + px) * 3) : '0;
        {p.out_red, p.out_green, p.out_blue} = line_st.line_color;
        p.last = line_st.major_pos == line_st.major_stop;
        pixel_q.push_back(p);
        if (p.last)
        begin
            drawing = 1'b0;
            return;
        end
        err  = line_st.err_term;
        dmaj = line_st.delta_major;
        dmin = line_st.delta_minor;
        err  = err - dmin;
        if (err < 0)
        begin
            line_st.minor_pos = line_st.minor_down ? line_st.minor_pos - 1'b1
                                                   : line_st.minor_pos + 1'b1;
            err = err + dmaj;
        end
        line_st.err_term  = bls_pkg::ERR_W'(err);
        line_st.major_pos = line_st.major_pos + 1'b1;
    endfunction

    function automatic void check_pixel(input bls_pkg::pix_item_t got);
        bls_pkg::pix_item_t want;
        logic               bad;
        if (pixel_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected pixel beat: %s", show(got));
            return;
        end
        want = pixel_q.pop_front();
        bad = got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
              got.inside_res !== want.inside_res || got.byte_offset !== want.byte_offset ||
              got.out_red !== want.out_red || got.out_green !== want.out_green ||
              got.out_blue !== want.out_blue || got.last !== want.last;
        if (bad)
        begin
            errors++;
            if (errors <= 10)
                $display("pixel mismatch\n  expected %s\n  actual   %s",
                         show(want), show(got));
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            line_st = '0;
            drawing = 1'b0;
            pixel_q.delete();
            errors  = 0;
        end
        else
        begin
            if (pix_valid && pix_ready)
                check_pixel(pix);
            if (cmd_valid && cmd_ready)
            begin
                if (cmd.mode == bls_pkg::MODE_LOAD)
                    start_line(cmd);
                else
                    next_pixel();
            end
        end
        pending = pixel_q.size();
    end

endmodule

>>> bench/bresenham_line_stepper_tb.sv
`timescale 1ns / 100ps
// Testbench top for the line stepper: clock, reset, command and pixel channel drivers.
// Depends on bls_pkg, bresenham_line_stepper and bresenham_line_stepper_chk.
module bresenham_line_stepper_tb;

    localparam int CMD_W = $bits(bls_pkg::cmd_item_t);

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    bls_pkg::cmd_item_t cmd       = '0;
    logic               pix_valid;
    logic               pix_ready = 1'b0;
    bls_pkg::pix_item_t pix;
    int                 errors;
    int                 pending;
    int                 hold_ask  = 0;
    int                 burst_left = 0;
    int                 sent      = 0;

    bresenham_line_stepper dut (.*);

    bresenham_line_stepper_chk chk (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // pixel channel: stall styles in segments, long hold-off on request
    initial
    begin : pixel_sink
        int style, seg_left, hold_left, hold_seen;
        style = 0;
        seg_left = 0;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pix_ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    style = $urandom_range(0, 2);
                    seg_left = $urandom_range(5, 60);
                end
                seg_left--;
                case (style)
                    0:       pix_ready <= 1'b1;
                    1:       pix_ready <= 1'($urandom_range(0, 1));
                    default: pix_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic put_beat(input bls_pkg::cmd_item_t c);
        int gap;
        cmd       <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
        sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic load_beat(input int x0, y0, x1, y1, input logic [23:0] rgb);
        bls_pkg::cmd_item_t c;
        c.mode    = bls_pkg::MODE_LOAD;
        c.x_start = bls_pkg::COORD_W'(x0);
        c.y_start = bls_pkg::COORD_W'(y0);
        c.x_end   = bls_pkg::COORD_W'(x1);
        c.y_end   = bls_pkg::COORD_W'(y1);
        {c.red, c.green, c.blue} = rgb;
        put_beat(c);
    endtask

    task automatic step_beats(input int n);
        bls_pkg::cmd_item_t c;
        repeat (n)
        begin
            c = CMD_W'({$urandom, $urandom, $urandom});
            c.mode = bls_pkg::MODE_STEP;
            put_beat(c);
        end
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        @(negedge clk);
    endtask

    function automatic int fit(input int v);
        return (v < -2048) ? -2048 : (v > 2047) ? 2047 : v;
    endfunction

    function automatic int pick_coord();
        int base;
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 4095)) - 2048;
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       base = 0;
                    1:       base = bls_pkg::IMAGE_WIDTH;
                    2:       base = -2048;
                    default: base = 2047;
                endcase
                return fit(base + int'($urandom_range(0, 6)) - 3);
            end
            default: return $urandom_range(0, bls_pkg::IMAGE_WIDTH - 1);
        endcase
    endfunction

    initial
    begin : stimulus
        int x0, y0, x1, y1, span, npix, cut, kind, lines;
        @(posedge rst_n);
        @(negedge clk);

        step_beats(1);
        load_beat(-2048, -2048, 2047, 2047, 24'hffffff);
        step_beats(3);
        load_beat(2047, 2047, -2048, -2048, 24'h000000);
        step_beats(2);
        load_beat(5, 5, 5, 5, 24'h123456);
        step_beats(2);
        load_beat(1597, 1599, 1601, 1600, 24'ha5c3e1);
        step_beats(5);
        load_beat(-1, 2, 0, -2, 24'h5a3c1e);
        step_beats(5);
        load_beat(0, 0, 2, 2, 24'h80ff01);
        step_beats(3);
        wait_drained();

        hold_ask <= hold_ask + 1;
        load_beat(100, 40, 140, 60, 24'($urandom));
        step_beats(41);
        wait_drained();

        lines = 0;
        while (sent < 450)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                step_beats(1);
                continue;
            end
            if ($urandom_range(0, 14) == 0)
            begin
                x0 = int'($urandom_range(0, 4095)) - 2048;
                y0 = int'($urandom_range(0, 4095)) - 2048;
                x1 = int'($urandom_range(0, 4095)) - 2048;
                y1 = int'($urandom_range(0, 4095)) - 2048;
            end
            else
            begin
                x0 = pick_coord();
                y0 = pick_coord();
                span = ($urandom_range(0, 39) == 0) ? $urandom_range(20, 150)
                                                    : $urandom_range(0, 12);
                x1 = fit(x0 + int'($urandom_range(0, 2 * span)) - span);
                y1 = fit(y0 + int'($urandom_range(0, 2 * span)) - span);
            end
            npix = (x1 > x0 ? x1 - x0 : x0 - x1);
            if ((y1 > y0 ? y1 - y0 : y0 - y1) > npix)
                npix = (y1 > y0 ? y1 - y0 : y0 - y1);
            npix = npix + 1;
            if (kind == 1 || npix > 160)
                cut = $urandom_range(0, (npix > 10) ? 10 : npix - 1);
            else
                cut = npix;
            load_beat(x0, y0, x1, y1, 24'($urandom));
            step_beats(cut);
            if (kind == 2 && cut == npix)
                step_beats(1);
            lines++;
            if (lines % 60 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
